// ===== rtl/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// tes_pkg
// Shared widths, register indexes, unit request types and the peak detector
// step function of the two-window t-statistic event segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

	localparam int unsigned RING_DEPTH_DEF = 64;
	localparam int unsigned MAX_WINDOW_DEF = 31;
	localparam int unsigned PADDR_W        = 5;

	localparam logic [2:0] REG_WINDOW_SHORT    = 3'd0;
	localparam logic [2:0] REG_WINDOW_LONG     = 3'd1;
	localparam logic [2:0] REG_THRESHOLD_SHORT = 3'd2;
	localparam logic [2:0] REG_THRESHOLD_LONG  = 3'd3;
	localparam logic [2:0] REG_PEAK_HEIGHT     = 3'd4;

	typedef struct packed {
		logic [47:0] mask_until;
		logic        has_peak;
		logic [47:0] peak_index;
		logic [15:0] peak_level;
		logic        confirmed;
	} det_t;

	typedef struct packed {
		det_t        st;
		logic        fire;
		logic        kill;
		logic [47:0] kill_mask;
	} det_res_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] root;
	} sqrt_rsp_t;

	function automatic logic [47:0] mag48(logic [47:0] v);
		return v[47] ? (48'd0 - v) : v;
	endfunction

	function automatic det_res_t det_step(det_t s, logic [15:0] cur, logic [47:0] c,
			logic [15:0] thr, logic [4:0] win, logic [15:0] ph);
		det_res_t    r;
		logic [15:0] lev;
		logic [47:0] idx;
		logic        cf;
		r      = '0;
		r.st   = s;
		lev    = s.peak_level;
		idx    = s.peak_index;
		cf     = s.confirmed;
		if (s.mask_until < c) begin
			if (!s.has_peak) begin
				if (cur < lev) begin
					r.st.peak_level = cur;
				end else if ((cur - lev) > ph) begin
					r.st.peak_level = cur;
					r.st.peak_index = c;
					r.st.has_peak   = 1'b1;
				end
			end else begin
				if (cur > lev) begin
					lev = cur;
					idx = c;
				end
				r.kill = lev > thr;
				if (lev > cur && (lev - cur) > ph && lev > thr) begin
					cf = 1'b1;
				end
				r.st.peak_level = lev;
				r.st.peak_index = idx;
				r.st.confirmed  = cf;
				if (cf && ((c - idx) > {44'd0, win[4:1]})) begin
					r.st.has_peak   = 1'b0;
					r.st.peak_level = cur;
					r.st.confirmed  = 1'b0;
					r.fire          = 1'b1;
				end
			end
		end
		r.kill_mask = idx + {43'd0, win};
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tes_if.sv =====
// ----------------------------------------------------------------------------
// tes_if
// Valid/ready stream interfaces for samples in and events out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tes_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface tes_event_if;
	logic               valid;
	logic               ready;
	logic               event_valid;
	logic [47:0]        event_start;
	logic [31:0]        event_length;
	logic signed [15:0] event_mean;
	logic [15:0]        event_stdv;

	modport source (output valid, output event_valid, output event_start,
		output event_length, output event_mean, output event_stdv, input ready);
	modport sink (input valid, input event_valid, input event_start,
		input event_length, input event_mean, input event_stdv, output ready);
endinterface

`default_nettype wire

// ===== rtl/tes_ring.sv =====
// ----------------------------------------------------------------------------
// tes_ring
// Ring memory of prefix sums and prefix square sums, one write and one
// registered read per cycle. Entry zero reads as zero until first written.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_ring import tes_pkg::*; #(
	parameter int unsigned DEPTH = RING_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(RING_DEPTH_DEF)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [47:0]   wr_sum,
	input  wire logic [63:0]   wr_square,
	input  wire logic [AW-1:0] rd_addr,
	output logic [47:0]        rd_sum,
	output logic [63:0]        rd_square
);

	logic [111:0] mem [DEPTH];
	logic [111:0] rd_q;
	logic         zero_q;
	logic         rd_zero_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_sum, wr_square};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q    <= 1'b1;
			rd_zero_q <= 1'b0;
		end else begin
			rd_zero_q <= zero_q && (rd_addr == '0);
			if (wr_en && wr_addr == '0) begin
				zero_q <= 1'b0;
			end
		end
	end

	assign rd_sum    = rd_zero_q ? 48'd0 : rd_q[111:64];
	assign rd_square = rd_zero_q ? 64'd0 : rd_q[63:0];

endmodule

`default_nettype wire

// ===== rtl/tes_divider.sv =====
// ----------------------------------------------------------------------------
// tes_divider
// Restoring 64-bit by 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_divider import tes_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam logic [6:0] STEPS = 7'd64;

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] div_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [64:0] shf;
	logic        ge;

	assign shf = {rem_q, quo_q[63]};
	assign ge  = shf >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1) && !req.start;
			if (req.start) begin
				cnt_q <= STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? 64'(shf - {1'b0, div_q}) : shf[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/tes_isqrt.sv =====
// ----------------------------------------------------------------------------
// tes_isqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_isqrt import tes_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire sqrt_req_t req,
	output sqrt_rsp_t      rsp
);

	localparam logic [5:0] STEPS = 6'd32;

	logic [33:0] rem_q;
	logic [63:0] rad_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [35:0] shf;
	logic [35:0] trial;
	logic        ge;

	assign shf   = {rem_q, rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = shf >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 6'd1) && !req.start;
			if (req.start) begin
				cnt_q <= STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			rad_q  <= req.radicand;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? 34'(shf - trial) : shf[33:0];
			root_q <= {root_q[30:0], ge};
			rad_q  <= {rad_q[61:0], 2'b00};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

`default_nettype wire

// ===== rtl/tstat_event_segmenter_core.sv =====
// ----------------------------------------------------------------------------
// tstat_event_segmenter_core
// Two-window t-statistic event segmenter: prefix ring, sequencer, shared
// divider and square root unit, peak detectors and event statistics.
//
//   Channel   Dir  Transfer when        Payload
//   in_ch     in   valid & ready        sample
//   out_ch    out  valid & ready        event_valid/start/length/mean/stdv
//   APB       in   psel&penable&pwrite  window, threshold and peak registers
//
// Each t-statistic that is not skipped runs ring reads and products, then the
// divider and the root unit unless its result is settled early, and an event
// adds two divisions and, when the variance is positive, one root. Reset is
// asynchronous and needs no clearing pass. in_ch is ready only between samples;
// a finished result waits in the output register while the next sample is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tstat_event_segmenter_core import tes_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	tes_sample_if.sink              in_ch,
	tes_event_if.source             out_ch,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int unsigned AW    = $clog2(RING_DEPTH);
	localparam logic [7:0]  MAXW  = 8'(MAX_WINDOW);
	localparam logic [8:0]  DEPTH = 9'(RING_DEPTH);

	typedef enum logic [20:0] {
		ST_IDLE  = 21'd1,
		ST_WR    = 21'd2,
		ST_TCHK  = 21'd4,
		ST_TIC   = 21'd8,
		ST_TIL   = 21'd16,
		ST_TIR   = 21'd32,
		ST_TCAP  = 21'd64,
		ST_TM1   = 21'd128,
		ST_TM2   = 21'd256,
		ST_TM3   = 21'd512,
		ST_TDIV  = 21'd1024,
		ST_TSQ   = 21'd2048,
		ST_DS    = 21'd4096,
		ST_DL    = 21'd8192,
		ST_EADR  = 21'd16384,
		ST_ECAP  = 21'd32768,
		ST_EDIV1 = 21'd65536,
		ST_EDIV2 = 21'd131072,
		ST_ESUB  = 21'd262144,
		ST_ESQ   = 21'd524288,
		ST_EMIT  = 21'd1048576
	} state_t;

	state_t state_q, state_d;

	logic [4:0]  ws_q, wl_q;
	logic [15:0] ths_q, thl_q, ph_q;

	logic [47:0] count_q;
	logic        widx_q;
	det_t        short_q, long_q;
	logic        fire_q;
	logic [47:0] begin_idx_q, begin_sum_q;
	logic [63:0] begin_sq_q;

	logic signed [15:0] x_q;
	logic signed [31:0] xsq_q;
	logic [47:0] ic_sum_q, il_sum_q;
	logic [63:0] ic_sq_q, il_sq_q;
	logic [20:0] m1_q, m2_q;
	logic [21:0] d_q;
	logic [36:0] qs_q;
	logic [41:0] m1sq_q, m2sq_q, wq_q, num_q;
	logic [43:0] dd_q;
	logic [47:0] a_q;
	logic [15:0] ts_q, tl_q;
	logic [47:0] len_q;
	logic [63:0] eq_q, msq_q;
	logic        sneg_q;
	logic signed [15:0] mean_q;
	logic [31:0] mm_q;

	logic               res_valid_q;
	logic [47:0]        res_start_q;
	logic [31:0]        res_len_q;
	logic signed [15:0] res_mean_q;
	logic [15:0]        res_stdv_q;

	logic               out_v_q;
	logic               out_ev_q;
	logic [47:0]        out_start_q;
	logic [31:0]        out_len_q;
	logic signed [15:0] out_mean_q;
	logic [15:0]        out_stdv_q;

	logic [AW-1:0] rd_addr;
	logic [47:0]   rd_sum;
	logic [63:0]   rd_sq;
	logic [47:0]   cnt1;
	logic          wr_en;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;

	logic [47:0] c_w, c_l, c_r;
	logic [4:0]  w_cur;
	logic [5:0]  wsum;
	logic        t_skip;
	logic        t_store;
	logic [15:0] t_val;
	logic [47:0] s1_w, s2_w, sd_w;
	logic [63:0] q1_w, q2_w, qs_w;
	logic [47:0] len_w, es_w, ems_w;
	logic [63:0] eq_w;
	logic [63:0] mq;
	logic signed [15:0] mean_w;
	logic signed [31:0] mm_s;
	logic        emit;
	logic        accept;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;
	det_res_t    det_r;
	logic        det_long;

	// Ring and arithmetic units.
	tes_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (cnt1[AW-1:0]),
		.wr_sum    (rd_sum + {{32{x_q[15]}}, x_q}),
		.wr_square (rd_sq + {32'd0, xsq_q}),
		.rd_addr   (rd_addr),
		.rd_sum    (rd_sum),
		.rd_square (rd_sq)
	);

	tes_divider u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	tes_isqrt   u_sqrt (.clk(clk), .arst_n(arst_n), .req(sq_req), .rsp(sq_rsp));

	assign accept  = in_ch.valid && (state_q == ST_IDLE);
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = state_q == ST_WR;
	assign cnt1    = count_q + 48'd1;
	assign emit    = (state_q == ST_EMIT) && (!out_v_q || out_ch.ready);

	assign c_w    = count_q - {43'd0, wl_q};
	assign w_cur  = widx_q ? wl_q : ws_q;
	assign c_l    = c_w - {43'd0, w_cur};
	assign c_r    = c_w + {43'd0, w_cur};
	assign wsum   = {1'b0, wl_q} + {1'b0, w_cur};
	assign t_skip = (w_cur < 5'd2) || ({3'd0, w_cur} > MAXW) || (w_cur > wl_q) ||
		({3'd0, wsum} >= DEPTH) || (count_q < {42'd0, wsum});

	assign s1_w = ic_sum_q - il_sum_q;
	assign s2_w = rd_sum - ic_sum_q;
	assign sd_w = s2_w - s1_w;
	assign q1_w = ic_sq_q - il_sq_q;
	assign q2_w = rd_sq - ic_sq_q;
	assign qs_w = q1_w + q2_w;

	assign len_w = c_w - begin_idx_q;
	assign es_w  = rd_sum - begin_sum_q;
	assign ems_w = mag48(es_w);
	assign eq_w  = rd_sq - begin_sq_q;

	assign mq = div_rsp.quotient;
	always_comb begin
		if (sneg_q) begin
			mean_w = (mq > 64'd32768) ? 16'sh8000 : $signed(16'(64'd0 - mq));
		end else begin
			mean_w = (mq > 64'd32767) ? 16'sh7fff : $signed(mq[15:0]);
		end
	end
	assign mm_s = mean_q * mean_q;

	assign det_long = state_q == ST_DL;
	assign det_r = det_step(det_long ? long_q : short_q, det_long ? tl_q : ts_q, c_w,
		det_long ? thl_q : ths_q, det_long ? wl_q : ws_q, ph_q);

	always_comb begin
		unique case (state_q)
			ST_TIC, ST_EADR: rd_addr = c_w[AW-1:0];
			ST_TIL:          rd_addr = c_l[AW-1:0];
			ST_TIR:          rd_addr = c_r[AW-1:0];
			default:         rd_addr = count_q[AW-1:0];
		endcase
	end

	always_comb begin
		state_d = state_q;
		div_req = '0;
		sq_req  = '0;
		t_store = 1'b0;
		t_val   = 16'd0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_WR;
			end
			ST_WR: state_d = ST_TCHK;
			ST_TCHK: begin
				if (t_skip) begin
					t_store = 1'b1;
					state_d = widx_q ? ST_DS : ST_TCHK;
				end else begin
					state_d = ST_TIC;
				end
			end
			ST_TIC:  state_d = ST_TIL;
			ST_TIL:  state_d = ST_TIR;
			ST_TIR:  state_d = ST_TCAP;
			ST_TCAP: state_d = ST_TM1;
			ST_TM1:  state_d = ST_TM2;
			ST_TM2:  state_d = ST_TM3;
			ST_TM3: begin
				if (num_q == '0) begin
					t_store = 1'b1;
					t_val   = (d_q == '0) ? 16'd0 : 16'hffff;
					state_d = widx_q ? ST_DS : ST_TCHK;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = {a_q, 16'd0};
					div_req.divisor  = {22'd0, num_q};
					state_d          = ST_TDIV;
				end
			end
			ST_TDIV: begin
				if (div_rsp.done) begin
					if (mq[63:32] != '0) begin
						t_store = 1'b1;
						t_val   = 16'hffff;
						state_d = widx_q ? ST_DS : ST_TCHK;
					end else begin
						sq_req.start    = 1'b1;
						sq_req.radicand = mq;
						state_d         = ST_TSQ;
					end
				end
			end
			ST_TSQ: begin
				if (sq_rsp.done) begin
					t_store = 1'b1;
					t_val   = sq_rsp.root[15:0];
					state_d = widx_q ? ST_DS : ST_TCHK;
				end
			end
			ST_DS:   state_d = ST_DL;
			ST_DL:   state_d = ST_EADR;
			ST_EADR: state_d = ST_ECAP;
			ST_ECAP: begin
				if (fire_q && len_w != '0) begin
					div_req.start    = 1'b1;
					div_req.dividend = {15'd0, ems_w, 1'b0} + {16'd0, len_w};
					div_req.divisor  = {15'd0, len_w, 1'b0};
					state_d          = ST_EDIV1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EDIV1: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = eq_q;
					div_req.divisor  = {16'd0, len_q};
					state_d          = ST_EDIV2;
				end
			end
			ST_EDIV2: begin
				if (div_rsp.done) state_d = ST_ESUB;
			end
			ST_ESUB: begin
				if (msq_q > {32'd0, mm_q}) begin
					sq_req.start    = 1'b1;
					sq_req.radicand = msq_q - {32'd0, mm_q};
					state_d         = ST_ESQ;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_ESQ: begin
				if (sq_rsp.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ws_q        <= 5'd3;
			wl_q        <= 5'd6;
			ths_q       <= 16'd358;
			thl_q       <= 16'd2304;
			ph_q        <= 16'd51;
			count_q     <= '0;
			widx_q      <= 1'b0;
			short_q     <= '{mask_until: '0, has_peak: 1'b0, peak_index: '0,
				peak_level: 16'hffff, confirmed: 1'b0};
			long_q      <= '{mask_until: '0, has_peak: 1'b0, peak_index: '0,
				peak_level: 16'hffff, confirmed: 1'b0};
			fire_q      <= 1'b0;
			begin_idx_q <= '0;
			begin_sum_q <= '0;
			begin_sq_q  <= '0;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_WINDOW_SHORT:    ws_q  <= pwdata[4:0];
					REG_WINDOW_LONG:     wl_q  <= pwdata[4:0];
					REG_THRESHOLD_SHORT: ths_q <= pwdata[15:0];
					REG_THRESHOLD_LONG:  thl_q <= pwdata[15:0];
					REG_PEAK_HEIGHT:     ph_q  <= pwdata[15:0];
					default: ;
				endcase
			end
			if (state_q == ST_WR) begin
				count_q <= cnt1;
				widx_q  <= 1'b0;
			end else if (t_store) begin
				widx_q <= 1'b1;
			end
			if (state_q == ST_DS) begin
				short_q <= det_r.st;
				fire_q  <= det_r.fire;
				if (det_r.kill) begin
					long_q.mask_until <= det_r.kill_mask;
					long_q.has_peak   <= 1'b0;
					long_q.peak_level <= 16'hffff;
					long_q.confirmed  <= 1'b0;
				end
			end
			if (state_q == ST_DL) begin
				long_q <= det_r.st;
				fire_q <= fire_q | det_r.fire;
			end
			if (state_q == ST_ECAP && fire_q) begin
				begin_idx_q <= c_w;
				begin_sum_q <= rd_sum;
				begin_sq_q  <= rd_sq;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= in_ch.sample;
			xsq_q <= in_ch.sample * in_ch.sample;
		end
		if (t_store) begin
			if (widx_q) begin
				tl_q <= t_val;
			end else begin
				ts_q <= t_val;
			end
		end
		if (state_q == ST_TIL) begin
			ic_sum_q <= rd_sum;
			ic_sq_q  <= rd_sq;
		end
		if (state_q == ST_TIR) begin
			il_sum_q <= rd_sum;
			il_sq_q  <= rd_sq;
		end
		if (state_q == ST_TCAP) begin
			m1_q <= 21'(mag48(s1_w));
			m2_q <= 21'(mag48(s2_w));
			d_q  <= 22'(mag48(sd_w));
			qs_q <= qs_w[36:0];
		end
		if (state_q == ST_TM1) begin
			m1sq_q <= 42'(m1_q) * 42'(m1_q);
			m2sq_q <= 42'(m2_q) * 42'(m2_q);
			wq_q   <= 42'(qs_q) * 42'(w_cur);
			dd_q   <= 44'(d_q) * 44'(d_q);
		end
		if (state_q == ST_TM2) begin
			num_q <= wq_q - m1sq_q - m2sq_q;
			a_q   <= 48'(dd_q) * 48'(w_cur);
		end
		if (state_q == ST_ECAP) begin
			len_q       <= len_w;
			eq_q        <= eq_w;
			sneg_q      <= es_w[47];
			res_valid_q <= fire_q;
			res_start_q <= fire_q ? begin_idx_q : 48'd0;
			res_len_q   <= !fire_q ? 32'd0 :
				((len_w[47:32] != '0) ? 32'hffffffff : len_w[31:0]);
			res_mean_q  <= '0;
			res_stdv_q  <= '0;
		end
		if (state_q == ST_EDIV1 && div_rsp.done) begin
			mean_q     <= mean_w;
			res_mean_q <= mean_w;
		end
		if (state_q == ST_EDIV2) begin
			mm_q <= mm_s;
			if (div_rsp.done) begin
				msq_q <= mq;
			end
		end
		if (state_q == ST_ESQ && sq_rsp.done) begin
			res_stdv_q <= (sq_rsp.root[31:16] != '0) ? 16'hffff : sq_rsp.root[15:0];
		end
		if (emit) begin
			out_ev_q    <= res_valid_q;
			out_start_q <= res_start_q;
			out_len_q   <= res_len_q;
			out_mean_q  <= res_mean_q;
			out_stdv_q  <= res_stdv_q;
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_WINDOW_SHORT:    prdata = {27'd0, ws_q};
			REG_WINDOW_LONG:     prdata = {27'd0, wl_q};
			REG_THRESHOLD_SHORT: prdata = {16'd0, ths_q};
			REG_THRESHOLD_LONG:  prdata = {16'd0, thl_q};
			REG_PEAK_HEIGHT:     prdata = {16'd0, ph_q};
			default:             prdata = 32'd0;
		endcase
	end

	assign in_ch.ready         = state_q == ST_IDLE;
	assign out_ch.valid        = out_v_q;
	assign out_ch.event_valid  = out_ev_q;
	assign out_ch.event_start  = out_start_q;
	assign out_ch.event_length = out_len_q;
	assign out_ch.event_mean   = out_mean_q;
	assign out_ch.event_stdv   = out_stdv_q;

endmodule

`default_nettype wire
